// ===== src/assert_macros.svh =====
// Assertion helpers used by the verification checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only out of reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked only out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== src/pftr_pkg.sv =====
package pftr_pkg;

    // Geometry of the translator.
    localparam int PAGE_COUNT  = 256;
    localparam int FRAME_COUNT = 128;
    localparam int OFFSET_BITS = 8;

    localparam int PAGE_W  = $clog2(PAGE_COUNT);
    localparam int FRAME_W = $clog2(FRAME_COUNT);
    localparam int FILL_W  = $clog2(FRAME_COUNT + 1);

    // Field widths of the stream payloads.
    localparam int VA_W       = 16;
    localparam int PA_W       = 15;
    localparam int FN_W       = 7;
    localparam int EP_W       = 8;
    localparam int FT_W       = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 2;

    localparam logic [FT_W-1:0] FAULT_MAX = '1;

    typedef logic [PAGE_W-1:0]  t_page;
    typedef logic [FRAME_W-1:0] t_frame;

    // Page table update issued when an item leaves the work stage.
    typedef struct packed {
        logic   map_en;
        t_page  map_page;
        t_frame map_frame;
        logic   inval_en;
        t_page  inval_page;
    } t_pt_upd;

    // Frame allocator status seen by the work stage.
    typedef struct packed {
        logic   full;
        t_frame frame;
        t_page  owner;
    } t_alloc;

endpackage

// ===== src/pftr_page_table.sv =====
module pftr_page_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  pftr_pkg::t_page   i_rd_page,
    input  pftr_pkg::t_pt_upd i_upd,
    output logic              o_lk_valid,
    output pftr_pkg::t_frame  o_lk_frame
);
    import pftr_pkg::*;

    logic   r_valid [PAGE_COUNT];
    t_frame frame_mem [PAGE_COUNT];
    logic   r_rd_valid;
    t_frame r_rd_frame;

    // Valid bits: a new mapping sets, an eviction clears.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PAGE_COUNT; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else begin
            for (int i = 0; i < PAGE_COUNT; i++) begin
                if (i_upd.map_en && (i_upd.map_page == t_page'(i))) begin
                    r_valid[i] <= 1'b1;
                end else if (i_upd.inval_en && (i_upd.inval_page == t_page'(i))) begin
                    r_valid[i] <= 1'b0;
                end
            end
        end
    end

    // Registered valid read, bypassed from the update of the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else if (i_rd_en) begin
            if (i_upd.map_en && (i_upd.map_page == i_rd_page)) begin
                r_rd_valid <= 1'b1;
            end else if (i_upd.inval_en && (i_upd.inval_page == i_rd_page)) begin
                r_rd_valid <= 1'b0;
            end else begin
                r_rd_valid <= r_valid[i_rd_page];
            end
        end
    end

    // Frame memory with write-first bypass on the registered read.
    always_ff @(posedge i_clk) begin
        if (i_upd.map_en) begin
            frame_mem[i_upd.map_page] <= i_upd.map_frame;
        end
        if (i_rd_en) begin
            if (i_upd.map_en && (i_upd.map_page == i_rd_page)) begin
                r_rd_frame <= i_upd.map_frame;
            end else begin
                r_rd_frame <= frame_mem[i_rd_page];
            end
        end
    end

    assign o_lk_valid = r_rd_valid;
    assign o_lk_frame = r_rd_frame;

endmodule

// ===== src/pftr_frame_alloc.sv =====
module pftr_frame_alloc (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_alloc_en,
    input  pftr_pkg::t_page  i_page,
    output pftr_pkg::t_alloc o_alloc
);
    import pftr_pkg::*;

    logic [FILL_W-1:0] r_filled;
    logic [FILL_W-1:0] n_filled;
    t_frame            r_victim;
    t_frame            n_victim;
    t_page             owner_mem [FRAME_COUNT];
    t_page             r_owner;
    logic              full;
    t_frame            frame;

    assign full  = (r_filled == FILL_W'(FRAME_COUNT));
    assign frame = full ? r_victim : r_filled[FRAME_W-1:0];

    // Free frames go out in order, then frames are reused round robin.
    always_comb begin
        n_filled = r_filled;
        n_victim = r_victim;
        if (i_alloc_en) begin
            if (!full) begin
                n_filled = r_filled + 1'b1;
            end else if (r_victim == FRAME_W'(FRAME_COUNT - 1)) begin
                n_victim = '0;
            end else begin
                n_victim = r_victim + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled <= '0;
            r_victim <= '0;
        end else begin
            r_filled <= n_filled;
            r_victim <= n_victim;
        end
    end

    // Reverse map; the owner of the next victim is read into a register ahead of its use.
    always_ff @(posedge i_clk) begin
        if (i_alloc_en) begin
            owner_mem[frame] <= i_page;
        end
        if (i_alloc_en && (frame == n_victim)) begin
            r_owner <= i_page;
        end else begin
            r_owner <= owner_mem[n_victim];
        end
    end

    assign o_alloc.full  = full;
    assign o_alloc.frame = frame;
    assign o_alloc.owner = r_owner;

endmodule

// ===== src/page_table_fifo_translator.sv =====
// An input is registered in the work stage, then its result in the output register.
// Throughput: one address per cycle while the output is not stalled; a page table
// read-modify-write per item, its read bypassed from the update of the item ahead.
// Reset (synchronous, active low) clears all valid bits, the frame allocator
// and the fault count; no clearing pass is needed.
module page_table_fifo_translator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [15:0] virtual_address
    input  logic [pftr_pkg::IN_DATA_W-1:0]   i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [14:0] physical_address, [21:15] frame_number, [29:22] evicted_page,
    // [45:30] fault_total, [47:46] zero
    output logic [pftr_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    // [0] page_fault, [1] evicted
    output logic [pftr_pkg::OUT_USER_W-1:0]  o_m_tuser
);
    import pftr_pkg::*;

    logic                   r_s1_valid;
    logic [VA_W-1:0]        r_s1_va;
    logic                   r_out_valid;
    logic [PA_W-1:0]        r_phys;
    logic [FN_W-1:0]        r_frame_num;
    logic                   r_fault;
    logic                   r_evicted;
    logic [EP_W-1:0]        r_ev_page;
    logic [FT_W-1:0]        r_fault_cnt;
    logic [FT_W-1:0]        n_fault_cnt;

    logic                   s1_adv;
    logic                   s_xfer;
    t_page                  rd_page;
    t_page                  s1_page;
    logic [OFFSET_BITS-1:0] s1_offset;
    logic                   lk_valid;
    t_frame                 lk_frame;
    t_alloc                 alloc;
    logic                   fault;
    logic                   evict;
    t_frame                 frame;
    t_pt_upd                upd;
    logic [FRAME_W+OFFSET_BITS-1:0] phys_wide;

    // Handshake: the work stage moves on when the output register is free.
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_s1_valid || s1_adv;
    assign s_xfer     = i_s_tvalid && o_s_tready;

    assign rd_page   = i_s_tdata[OFFSET_BITS +: PAGE_W];
    assign s1_page   = r_s1_va[OFFSET_BITS +: PAGE_W];
    assign s1_offset = r_s1_va[OFFSET_BITS-1:0];

    pftr_page_table u_page_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (s_xfer),
        .i_rd_page  (rd_page),
        .i_upd      (upd),
        .o_lk_valid (lk_valid),
        .o_lk_frame (lk_frame)
    );

    pftr_frame_alloc u_frame_alloc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_alloc_en (s1_adv && fault),
        .i_page     (s1_page),
        .o_alloc    (alloc)
    );

    // Translation of the item in the work stage.
    assign fault     = !lk_valid;
    assign evict     = fault && alloc.full;
    assign frame     = fault ? alloc.frame : lk_frame;
    assign phys_wide = {frame, s1_offset};

    assign upd.map_en     = s1_adv && fault;
    assign upd.map_page   = s1_page;
    assign upd.map_frame  = frame;
    assign upd.inval_en   = s1_adv && evict;
    assign upd.inval_page = alloc.owner;

    // Saturating fault count.
    always_comb begin
        n_fault_cnt = r_fault_cnt;
        if (fault && (r_fault_cnt != FAULT_MAX)) begin
            n_fault_cnt = r_fault_cnt + 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fault_cnt <= '0;
        end else begin
            if (s_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_fault_cnt <= n_fault_cnt;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input and result payload registers.
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_s1_va <= i_s_tdata[VA_W-1:0];
        end
        if (s1_adv) begin
            r_phys      <= PA_W'(phys_wide);
            r_frame_num <= FN_W'(frame);
            r_fault     <= fault;
            r_evicted   <= evict;
            r_ev_page   <= evict ? EP_W'(alloc.owner) : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_fault_cnt, r_ev_page, r_frame_num, r_phys};
    assign o_m_tuser  = {r_evicted, r_fault};

endmodule

// ===== src/pftr_checker.sv =====
`include "assert_macros.svh"

module pftr_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic [pftr_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [pftr_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    input logic [pftr_pkg::OUT_USER_W-1:0]  o_m_tuser
);
    import pftr_pkg::*;

    logic unused_in;
    assign unused_in = i_s_tvalid ^ o_s_tready ^ (^i_s_tdata);

    // A replacement only happens on a fault.
    `ASSERT_IMPLIES(a_evict_needs_fault, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[1], o_m_tuser[0])

    // A hit carries no evicted page.
    `ASSERT_IMPLIES(a_hit_no_evict, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser[0], o_m_tuser[1] == 1'b0 && o_m_tdata[29:22] == 8'd0)

    // The upper bits of the physical address are the frame number.
    `ASSERT_IMPLIES(a_phys_frame, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[14:8] == o_m_tdata[21:15])

    // A stalled result holds.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))

endmodule

bind page_table_fifo_translator pftr_checker u_pftr_checker (.*);
